@@ src/stl_pkg.sv @@
// Shared types, constants and match tables for the script token lexer.
`default_nettype none
package stl_pkg;

  localparam int STL_LENGTH_LIMIT = 255;
  localparam int STL_OFFSET_BITS  = 32;
  localparam int STL_QUEUE_DEPTH  = 4;
  localparam int OUT_DEPTH        = 4;
  localparam int OUT_AW           = $clog2(OUT_DEPTH);

  localparam logic [3:0] SPI_RESET = 4'd4;
  localparam logic       REG_SPACES_PER_INDENT = 1'b0;

  // token kinds
  localparam logic [5:0] K_END       = 6'd0;
  localparam logic [5:0] K_ENDLINE   = 6'd1;
  localparam logic [5:0] K_INDENT    = 6'd2;
  localparam logic [5:0] K_NUMBER    = 6'd3;
  localparam logic [5:0] K_DOT       = 6'd4;
  localparam logic [5:0] K_IDENT     = 6'd5;
  localparam logic [5:0] K_CALL      = 6'd6;
  localparam logic [5:0] K_FN        = 6'd7;
  localparam logic [5:0] K_LET       = 6'd8;
  localparam logic [5:0] K_THEN      = 6'd9;
  localparam logic [5:0] K_RETURN    = 6'd10;
  localparam logic [5:0] K_WHILE     = 6'd11;
  localparam logic [5:0] K_IF        = 6'd12;
  localparam logic [5:0] K_BOOL      = 6'd13;
  localparam logic [5:0] K_STRING    = 6'd14;
  localparam logic [5:0] K_DIRECTIVE = 6'd15;
  localparam logic [5:0] K_COMMA     = 6'd16;
  localparam logic [5:0] K_LPAREN    = 6'd17;
  localparam logic [5:0] K_RPAREN    = 6'd18;
  localparam logic [5:0] K_OP_FIRST  = 6'd19;  // operators follow OP_TEXT order
  localparam logic [5:0] K_ERROR     = 6'd40;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       digit;
    logic       alpha;
    logic       dot;
    logic       blank;
    logic       tab;
    logic       newline;
    logic       nul;
    logic       quote;
    logic       hash;
    logic       comma;
    logic       lparen;
    logic       rparen;
    logic       sym;
  } stl_class_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] start;
    logic [7:0]  length;
    logic        last;
  } stl_token_t;

  // text packed first byte in the low bits, so literals are written reversed
  localparam logic [47:0] KW_TEXT [8] = '{
    48'("nf"), 48'("tel"), 48'("neht"), 48'("nruter"),
    48'("elihw"), 48'("fi"), 48'("eurt"), 48'("eslaf")
  };
  localparam logic [2:0] KW_LEN [8] = '{
    3'd2, 3'd3, 3'd4, 3'd6, 3'd5, 3'd2, 3'd4, 3'd5
  };
  localparam logic [5:0] KW_KIND [8] = '{
    K_FN, K_LET, K_THEN, K_RETURN, K_WHILE, K_IF, K_BOOL, K_BOOL
  };

  localparam logic [23:0] OP_TEXT [21] = '{
    24'("!"), 24'("&&"), 24'("||"), 24'("=="), 24'("=!"), 24'("=>"), 24'("=<"),
    24'(">"), 24'("<"), 24'("="), 24'("=+"), 24'("=-"), 24'("=*"), 24'("=/"),
    24'("+"), 24'("++"), 24'("-"), 24'("--"), 24'("*"), 24'("/"), 24'("^")
  };
  localparam logic [2:0] OP_LEN [21] = '{
    3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd1, 3'd2, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1
  };

  // len is the text length, 7 standing for anything longer than six
  function automatic logic [5:0] word_kind(input logic [47:0] prefix,
                                           input logic [2:0] len,
                                           input logic paren);
    logic [5:0] k;
    k = paren ? K_CALL : K_IDENT;
    for (int i = 0; i < 8; i++) begin
      if (KW_LEN[i] == len && KW_TEXT[i] == prefix) k = KW_KIND[i];
    end
    return k;
  endfunction

  function automatic logic [5:0] symbol_kind(input logic [23:0] prefix,
                                             input logic [2:0] len);
    logic [5:0] k;
    k = K_ERROR;
    for (int i = 0; i < 21; i++) begin
      if (OP_LEN[i] == len && OP_TEXT[i] == prefix) k = K_OP_FIRST + 6'(i);
    end
    return k;
  endfunction

endpackage
`default_nettype wire

@@ src/stl_chars_if.sv @@
// Source byte channel.
`default_nettype none
interface stl_chars_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_input;

  modport source (output valid, output source_byte, output end_of_input, input ready);
  modport sink (input valid, input source_byte, input end_of_input, output ready);
endinterface
`default_nettype wire

@@ src/stl_tokens_if.sv @@
// Token result channel.
`default_nettype none
interface stl_tokens_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [31:0] token_start;
  logic [7:0]  token_length;
  logic        last;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input last, output ready);
endinterface
`default_nettype wire

@@ src/script_token_lexer.sv @@
// Top level of the script token lexer: front end, request queue, lexer core, APB register.
// The lexer takes one source byte per clock when the request queue has room and emits
// tokens (kind, start offset, length) as soon as each is known. A byte that closes one
// token and starts another yields two tokens, written into the result buffer together;
// other bytes yield zero or one. The front end classifies a byte and tags it with its
// offset in the cycle it is accepted; the byte is registered in the request queue, the
// core takes it from there and writes its tokens into a four-entry result buffer. The
// request queue keeps taking bytes while results wait, until it is full. Sustained input
// rate is one byte per cycle while the output is ready, limited by the one-token-per-cycle
// output when bytes produce two tokens. spaces_per_indent sits at byte address 0 (reset
// 4); the user must write it only while the lexer is idle; the block does not enforce it.
`default_nettype none
module script_token_lexer #(
  parameter int LENGTH_LIMIT = stl_pkg::STL_LENGTH_LIMIT,
  parameter int OFFSET_BITS  = stl_pkg::STL_OFFSET_BITS,
  parameter int QUEUE_DEPTH  = stl_pkg::STL_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  stl_chars_if.sink   chars,
  stl_tokens_if.source tokens,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QW = $bits(stl_pkg::stl_class_t) + OFFSET_BITS;

  logic [3:0]             spaces_per_indent;
  logic                   f_valid, f_ready;
  stl_pkg::stl_class_t    f_class;
  logic [OFFSET_BITS-1:0] f_off;
  logic                   b_valid, b_ready;
  stl_pkg::stl_class_t    b_class;
  logic [OFFSET_BITS-1:0] b_off;
  logic [QW-1:0]          q_wdata, q_rdata;
  logic                   reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2:2] == stl_pkg::REG_SPACES_PER_INDENT);
  assign prdata  = reg_hit ? {28'd0, spaces_per_indent} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      spaces_per_indent <= stl_pkg::SPI_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      spaces_per_indent <= pwdata[3:0];
    end
  end

  stl_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_class (f_class),
    .q_off   (f_off)
  );

  assign q_wdata = {f_class, f_off};
  assign {b_class, b_off} = q_rdata;

  stl_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (q_wdata),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (q_rdata)
  );

  stl_back #(
    .LENGTH_LIMIT(LENGTH_LIMIT),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .spaces_per_indent (spaces_per_indent),
    .in_valid          (b_valid),
    .in_ready          (b_ready),
    .in_class          (b_class),
    .in_off            (b_off),
    .tokens            (tokens)
  );

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    tokens.valid |-> (tokens.token_kind <= stl_pkg::K_ERROR))
    else $error("token kind out of range");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && tokens.token_kind == stl_pkg::K_END) |-> tokens.last)
    else $error("end token not marked last");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && (tokens.token_kind == stl_pkg::K_END ||
                      tokens.token_kind == stl_pkg::K_ENDLINE ||
                      tokens.token_kind == stl_pkg::K_INDENT))
    |-> (tokens.token_length == 8'd0))
    else $error("textless token with nonzero length");

endmodule
`default_nettype wire

@@ src/stl_front.sv @@
// Front end: takes source bytes, classifies them and tags each with its offset.
`default_nettype none
module stl_front #(
  parameter int OFFSET_BITS = stl_pkg::STL_OFFSET_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  stl_chars_if.sink              chars,
  output logic                   q_valid,
  input  logic                   q_ready,
  output stl_pkg::stl_class_t    q_class,
  output logic [OFFSET_BITS-1:0] q_off
);

  logic [OFFSET_BITS-1:0] byte_offset;
  logic [7:0]             ch;
  logic                   push;

  assign ch          = chars.source_byte;
  assign chars.ready = q_ready;
  assign q_valid     = chars.valid;
  assign push        = chars.valid && q_ready;
  assign q_off       = byte_offset;

  always_comb begin
    q_class.ch      = ch;
    q_class.eoi     = chars.end_of_input;
    q_class.digit   = (ch >= "0") && (ch <= "9");
    q_class.alpha   = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    q_class.dot     = (ch == ".");
    q_class.tab     = (ch == 8'h09);
    q_class.blank   = (ch == " ") || (ch == 8'h09) || (ch == 8'h0B) ||
                      (ch == 8'h0C) || (ch == 8'h0D);
    q_class.newline = (ch == 8'h0A);
    q_class.nul     = (ch == 8'h00);
    q_class.quote   = (ch == 8'h22);
    q_class.hash    = (ch == "#");
    q_class.comma   = (ch == ",");
    q_class.lparen  = (ch == "(");
    q_class.rparen  = (ch == ")");
    q_class.sym     = !(q_class.digit || q_class.alpha || q_class.blank ||
                        q_class.newline || q_class.nul || q_class.comma ||
                        q_class.lparen || q_class.rparen);
  end

  // end-of-input requests do not consume an offset
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
    end else if (push && !chars.end_of_input) begin
      byte_offset <= byte_offset + OFFSET_BITS'(1);
    end
  end

endmodule
`default_nettype wire

@@ src/stl_queue.sv @@
// Small register FIFO between the front end and the lexer core.
`default_nettype none
module stl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = stl_pkg::STL_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [AW:0]      count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      if (pop)  rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

@@ src/stl_back.sv @@
// Lexer core: token state machine and the result buffer that feeds the output.
`default_nettype none
module stl_back #(
  parameter int LENGTH_LIMIT = stl_pkg::STL_LENGTH_LIMIT,
  parameter int OFFSET_BITS  = stl_pkg::STL_OFFSET_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [3:0]             spaces_per_indent,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  stl_pkg::stl_class_t    in_class,
  input  logic [OFFSET_BITS-1:0] in_off,
  stl_tokens_if.source           tokens
);

  localparam int LW = $clog2(LENGTH_LIMIT + 1);
  localparam int OAW = stl_pkg::OUT_AW;

  typedef enum logic [6:0] {
    M_IDLE      = 7'b0000001,
    M_NUMBER    = 7'b0000010,
    M_WORD      = 7'b0000100,
    M_STRING    = 7'b0001000,
    M_DIRECTIVE = 7'b0010000,
    M_SYMBOL    = 7'b0100000,
    M_COMMENT   = 7'b1000000
  } mode_t;

  mode_t                  mode, mode_next;
  logic [3:0]             space_run, space_run_next;
  logic [47:0]            word_prefix, word_prefix_next;
  logic [23:0]            symbol_prefix, symbol_prefix_next;
  logic [LW-1:0]          text_length, text_length_next;
  logic [OFFSET_BITS-1:0] start_offset, start_offset_next;

  stl_pkg::stl_token_t    oq [stl_pkg::OUT_DEPTH];
  logic [OAW-1:0]         wp, rp;
  logic [OAW:0]           ocount;

  logic                   take;
  logic                   pop;
  stl_pkg::stl_class_t    c;

  logic [LW-1:0]          len_grow;
  logic [2:0]             short_len;
  logic                   flush_has;
  logic [5:0]             flush_kind;
  logic [3:0]             sr_inc;
  logic [OFFSET_BITS-1:0] blank_start;
  logic                   indent_now;

  // outcome of lexing the byte from idle
  logic                   id_v;
  logic [5:0]             id_kind;
  logic [OFFSET_BITS-1:0] id_start;
  logic [LW-1:0]          id_len;
  mode_t                  id_mode;
  logic [3:0]             id_sr;
  logic [OFFSET_BITS-1:0] id_so;
  logic [LW-1:0]          id_tl;
  logic [47:0]            id_wp;
  logic [23:0]            id_sp;

  logic                   do_fti;
  logic                   r0_v, r1_v;
  stl_pkg::stl_token_t    r0, r1;

  assign c        = in_class;
  assign in_ready = (ocount <= (OAW+1)'(stl_pkg::OUT_DEPTH - 2));
  assign take     = in_valid && in_ready;
  assign pop      = tokens.valid && tokens.ready;

  assign tokens.valid        = (ocount != '0);
  assign tokens.token_kind   = oq[rp].kind;
  assign tokens.token_start  = oq[rp].start;
  assign tokens.token_length = oq[rp].length;
  assign tokens.last         = oq[rp].last;

  assign len_grow  = (text_length < LW'(LENGTH_LIMIT)) ? text_length + LW'(1) : text_length;
  assign short_len = (text_length > LW'(6)) ? 3'd7 : text_length[2:0];
  assign sr_inc    = (space_run == 4'd15) ? space_run : space_run + 4'd1;
  assign blank_start = (space_run == 4'd0) ? in_off : start_offset;
  assign indent_now  = c.tab || ((spaces_per_indent != 4'd0) && (sr_inc >= spaces_per_indent));

  always_comb begin
    flush_has  = 1'b1;
    flush_kind = stl_pkg::K_ERROR;
    case (mode)
      M_NUMBER: begin
        flush_kind = (text_length == LW'(1) && word_prefix[7:0] == ".") ?
                     stl_pkg::K_DOT : stl_pkg::K_NUMBER;
      end
      M_WORD: begin
        flush_kind = stl_pkg::word_kind(word_prefix, short_len, c.lparen && !c.eoi);
      end
      M_STRING:    flush_kind = stl_pkg::K_ERROR;  // unterminated
      M_DIRECTIVE: flush_kind = stl_pkg::K_DIRECTIVE;
      M_SYMBOL:    flush_kind = stl_pkg::symbol_kind(symbol_prefix, short_len);
      default:     flush_has = 1'b0;
    endcase
  end

  always_comb begin
    id_v     = 1'b0;
    id_kind  = stl_pkg::K_ENDLINE;
    id_start = in_off;
    id_len   = '0;
    id_mode  = M_IDLE;
    id_sr    = 4'd0;
    id_so    = start_offset;
    id_tl    = text_length;
    id_wp    = word_prefix;
    id_sp    = symbol_prefix;
    if (c.nul) begin
      id_sr = space_run;
    end else if (c.newline) begin
      id_v = 1'b1;
    end else if (c.blank) begin
      id_so = blank_start;
      if (indent_now) begin
        id_v     = 1'b1;
        id_kind  = stl_pkg::K_INDENT;
        id_start = blank_start;
      end else begin
        id_sr = sr_inc;
      end
    end else if (c.digit || c.dot) begin
      id_mode = M_NUMBER;
      id_so   = in_off;
      id_tl   = LW'(1);
      id_wp   = {40'd0, c.ch};
    end else if (c.alpha) begin
      id_mode = M_WORD;
      id_so   = in_off;
      id_tl   = LW'(1);
      id_wp   = {40'd0, c.ch};
    end else if (c.quote) begin
      id_mode = M_STRING;
      id_so   = in_off;
      id_tl   = '0;
    end else if (c.hash) begin
      id_mode = M_DIRECTIVE;
      id_so   = in_off;
      id_tl   = '0;
    end else if (c.comma || c.lparen || c.rparen) begin
      id_v    = 1'b1;
      id_len  = LW'(1);
      id_kind = c.comma ? stl_pkg::K_COMMA :
                c.lparen ? stl_pkg::K_LPAREN : stl_pkg::K_RPAREN;
    end else begin
      id_mode = M_SYMBOL;
      id_so   = in_off;
      id_tl   = LW'(1);
      id_sp   = {16'd0, c.ch};
    end
  end

  always_comb begin
    mode_next          = mode;
    space_run_next     = space_run;
    word_prefix_next   = word_prefix;
    symbol_prefix_next = symbol_prefix;
    text_length_next   = text_length;
    start_offset_next  = start_offset;
    do_fti = 1'b0;
    r0_v   = 1'b0;
    r1_v   = 1'b0;
    r0.kind   = flush_kind;
    r0.start  = 32'(start_offset);
    r0.length = 8'(text_length);
    r0.last   = 1'b1;
    r1.kind   = id_kind;
    r1.start  = 32'(id_start);
    r1.length = 8'(id_len);
    r1.last   = 1'b1;
    if (take) begin
      if (c.eoi) begin
        // pending token, then the end token
        r0_v = flush_has;
        r1_v = 1'b1;
        r1.kind   = stl_pkg::K_END;
        r1.start  = 32'(in_off);
        r1.length = 8'd0;
        mode_next      = M_IDLE;
        space_run_next = 4'd0;
      end else begin
        case (mode)
          M_STRING: begin
            if (c.quote) begin
              r0_v = 1'b1;
              r0.kind = stl_pkg::K_STRING;
              mode_next = M_IDLE;
            end else begin
              text_length_next = len_grow;
            end
          end
          M_COMMENT: begin
            if (c.newline) do_fti = 1'b1;
          end
          M_DIRECTIVE: begin
            if (c.digit || c.alpha) begin
              text_length_next = len_grow;
            end else begin
              // terminating byte is swallowed
              r0_v = 1'b1;
              mode_next = M_IDLE;
            end
          end
          M_NUMBER: begin
            if (c.digit || c.dot) text_length_next = len_grow;
            else do_fti = 1'b1;
          end
          M_WORD: begin
            if (c.digit || c.alpha) begin
              for (int i = 0; i < 6; i++) begin
                if (text_length == LW'(i)) word_prefix_next[8*i +: 8] = c.ch;
              end
              text_length_next = len_grow;
            end else begin
              do_fti = 1'b1;
            end
          end
          M_SYMBOL: begin
            if (c.sym) begin
              for (int i = 0; i < 3; i++) begin
                if (text_length == LW'(i)) symbol_prefix_next[8*i +: 8] = c.ch;
              end
              text_length_next = len_grow;
              if (text_length == LW'(1) && symbol_prefix[7:0] == "/" && c.ch == "/")
                mode_next = M_COMMENT;
            end else begin
              do_fti = 1'b1;
            end
          end
          default: do_fti = 1'b1;
        endcase
        if (do_fti) begin
          r0_v = flush_has;
          r1_v = id_v;
          mode_next          = id_mode;
          space_run_next     = id_sr;
          word_prefix_next   = id_wp;
          symbol_prefix_next = id_sp;
          text_length_next   = id_tl;
          start_offset_next  = id_so;
        end
      end
      // compact into slot 0 when only the second result exists
      if (!r0_v && r1_v) begin
        r0   = r1;
        r0_v = 1'b1;
        r1_v = 1'b0;
      end
      r0.last = !r1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (r0_v) oq[wp] <= r0;
    if (r1_v) oq[wp + OAW'(1)] <= r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      space_run     <= 4'd0;
      word_prefix   <= '0;
      symbol_prefix <= '0;
      text_length   <= '0;
      start_offset  <= '0;
      wp            <= '0;
      rp            <= '0;
      ocount        <= '0;
    end else begin
      mode          <= mode_next;
      space_run     <= space_run_next;
      word_prefix   <= word_prefix_next;
      symbol_prefix <= symbol_prefix_next;
      text_length   <= text_length_next;
      start_offset  <= start_offset_next;
      wp            <= wp + OAW'(r0_v) + OAW'(r1_v);
      if (pop) rp <= rp + OAW'(1);
      ocount <= ocount + (OAW+1)'(r0_v) + (OAW+1)'(r1_v) - (OAW+1)'(pop);
    end
  end

endmodule
`default_nettype wire
